[sv/lse_pkg.sv]
`timescale 1ns / 1ps

package lse_pkg;

	localparam int CRD_W      = 32;
	localparam int DIR_W      = 16;
	localparam int DIST_W     = 33;
	localparam int PWR_W      = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_TYPE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VEC_X = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VEC_Y = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_VEC_Z = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_POWER = 3'd4;

	localparam int MAG_W    = 32;
	localparam int SQ_W     = 2 * MAG_W;
	localparam int SUM_W    = SQ_W + 2;
	localparam int ROOT_W   = SUM_W / 2;
	localparam int KINV_W   = 29;
	localparam int INUM_W   = PWR_W + KINV_W;
	localparam int IDEN_W   = SQ_W;
	localparam int IQ_W     = PWR_W;
	localparam int FRAC_DIR = 14;
	localparam int DQ_W     = FRAC_DIR + 1;
	localparam int DNUM_W   = MAG_W + FRAC_DIR + 1;
	localparam int DDEN_W   = ROOT_W;

	// round(2^32 / (4*pi))
	localparam logic [KINV_W-1:0] INV_FOUR_PI = 29'd341782638;

	typedef struct packed {
		logic                       point;
		logic [2:0]                 neg;
		logic [2:0][MAG_W-1:0]      mag;
		logic                       s_zero;
		logic                       force_max;
		logic                       force_zero;
		logic [PWR_W-1:0]           power;
		logic [INUM_W-1:0]          inum;
		logic [IDEN_W-1:0]          iden;
	} sq_side_t;

	typedef struct packed {
		logic                       point;
		logic [2:0]                 neg;
		logic                       s_zero;
		logic                       force_max;
		logic                       force_zero;
		logic [PWR_W-1:0]           power;
		logic [ROOT_W-1:0]          len;
		logic [2:0][DNUM_W-1:0]     dnum;
		logic [DDEN_W-1:0]          dden;
	} id_side_t;

	typedef struct packed {
		logic                       point;
		logic [2:0]                 neg;
		logic                       s_zero;
		logic [ROOT_W-1:0]          len;
		logic [PWR_W-1:0]           inten;
	} dd_side_t;

endpackage

[sv/lse_if.sv]
`timescale 1ns / 1ps

interface lse_hit_if import lse_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [CRD_W-1:0] hit_x;
	logic signed [CRD_W-1:0] hit_y;
	logic signed [CRD_W-1:0] hit_z;

	modport source (output valid, hit_x, hit_y, hit_z, input ready);
	modport sink (input valid, hit_x, hit_y, hit_z, output ready);
endinterface

interface lse_res_if import lse_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [DIR_W-1:0] dir_x;
	logic signed [DIR_W-1:0] dir_y;
	logic signed [DIR_W-1:0] dir_z;
	logic [DIST_W-1:0]       light_distance;
	logic                    distance_infinite;
	logic [PWR_W-1:0]        arriving_intensity;
	logic                    zero_vector;

	modport source (output valid, dir_x, dir_y, dir_z, light_distance, distance_infinite,
		arriving_intensity, zero_vector, input ready);
	modport sink (input valid, dir_x, dir_y, dir_z, light_distance, distance_infinite,
		arriving_intensity, zero_vector, output ready);
endinterface

interface lse_cfg_if import lse_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[sv/lse_front.sv]
`timescale 1ns / 1ps

module lse_front import lse_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [2:0][CRD_W-1:0]      hit,
	input  logic                       point,
	input  logic [2:0][CRD_W-1:0]      lvec,
	input  logic [PWR_W-1:0]           power,
	output logic                       out_valid,
	output sq_side_t                   side,
	output logic [SUM_W-1:0]           sum
);

	logic                  vld_s1, vld_s2, vld_s3, vld_s4;
	logic                  point_s1, point_s2, point_s3;
	logic [2:0]            neg_s1, neg_s2, neg_s3;
	logic [2:0][MAG_W-1:0] mag_s1, mag_s2, mag_s3;
	logic [PWR_W-1:0]      power_s1, power_s2, power_s3;
	logic [2:0][SQ_W-1:0]  sq_s2;
	logic [INUM_W-1:0]     prod_s2, prod_s3;
	logic [SUM_W-1:0]      sum_s3, sum_s4;
	sq_side_t              side_s4;

	logic [2:0][CRD_W:0]   v;
	logic [2:0][CRD_W:0]   v_neg;
	logic                  s_zero, s_big, ovf, use_div;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (point)
				v[i] = {lvec[i][CRD_W-1], lvec[i]} - {hit[i][CRD_W-1], hit[i]};
			else
				v[i] = '0 - {lvec[i][CRD_W-1], lvec[i]};
			v_neg[i] = '0 - v[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			point_s1 <= point;
			power_s1 <= power;
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= v[i][CRD_W];
				mag_s1[i] <= v[i][CRD_W] ? v_neg[i][MAG_W-1:0] : v[i][MAG_W-1:0];
			end

			point_s2 <= point_s1;
			power_s2 <= power_s1;
			neg_s2   <= neg_s1;
			mag_s2   <= mag_s1;
			for (int i = 0; i < 3; i++)
				sq_s2[i] <= SQ_W'(mag_s1[i]) * SQ_W'(mag_s1[i]);
			prod_s2  <= INUM_W'(power_s1) * INUM_W'(INV_FOUR_PI);

			point_s3 <= point_s2;
			power_s3 <= power_s2;
			neg_s3   <= neg_s2;
			mag_s3   <= mag_s2;
			prod_s3  <= prod_s2;
			sum_s3   <= SUM_W'(sq_s2[0]) + SUM_W'(sq_s2[1]) + SUM_W'(sq_s2[2]);

			sum_s4              <= sum_s3;
			side_s4.point       <= point_s3;
			side_s4.neg         <= neg_s3;
			side_s4.mag         <= mag_s3;
			side_s4.power       <= power_s3;
			side_s4.s_zero      <= s_zero;
			side_s4.force_max   <= s_zero | (!s_big & ovf);
			side_s4.force_zero  <= s_big;
			side_s4.inum        <= use_div ? prod_s3 : '0;
			side_s4.iden        <= use_div ? sum_s3[IDEN_W-1:0] : IDEN_W'(1);
		end
	end

	assign s_zero  = (sum_s3 == '0);
	assign s_big   = |sum_s3[SUM_W-1:IDEN_W];
	assign ovf     = IDEN_W'(prod_s3[INUM_W-1:IQ_W]) >= sum_s3[IDEN_W-1:0];
	assign use_div = !s_zero && !s_big && !ovf;

	assign out_valid = vld_s4;
	assign side      = side_s4;
	assign sum       = sum_s4;

endmodule

[sv/lse_sqrt.sv]
`timescale 1ns / 1ps

module lse_sqrt import lse_pkg::*; #(
	parameter int RT_W   = ROOT_W,
	parameter int SIDE_W = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [2*RT_W-1:0]   rad,
	input  logic [SIDE_W-1:0]   side_in,
	output logic                out_valid,
	output logic [RT_W-1:0]     root,
	output logic [SIDE_W-1:0]   side_out
);

	localparam int REM_W = RT_W + 2;

	logic [RT_W-1:0]                 vld_s;
	logic [RT_W-1:0][2*RT_W-1:0]     rad_s;
	logic [RT_W-1:0][REM_W-1:0]      rem_s;
	logic [RT_W-1:0][RT_W-1:0]       root_s;
	logic [RT_W-1:0][SIDE_W-1:0]     side_s;

	for (genvar k = 0; k < RT_W; k++) begin : g_stage
		logic                p_vld;
		logic [2*RT_W-1:0]   p_rad;
		logic [REM_W-1:0]    p_rem;
		logic [RT_W-1:0]     p_root;
		logic [SIDE_W-1:0]   p_side;
		logic [REM_W+1:0]    t;
		logic [REM_W+1:0]    trial;
		logic                ge;

		if (k == 0) begin : g_first
			assign p_vld  = in_valid;
			assign p_rad  = rad;
			assign p_rem  = '0;
			assign p_root = '0;
			assign p_side = side_in;
		end else begin : g_next
			assign p_vld  = vld_s[k-1];
			assign p_rad  = rad_s[k-1];
			assign p_rem  = rem_s[k-1];
			assign p_root = root_s[k-1];
			assign p_side = side_s[k-1];
		end

		assign t     = {p_rem, p_rad[2*RT_W-1 -: 2]};
		assign trial = (REM_W+2)'({p_root, 2'b01});
		assign ge    = t >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= p_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k]  <= {p_rad[2*RT_W-3:0], 2'b00};
				rem_s[k]  <= ge ? REM_W'(t - trial) : REM_W'(t);
				root_s[k] <= {p_root[RT_W-2:0], ge};
				side_s[k] <= p_side;
			end
		end
	end

	assign out_valid = vld_s[RT_W-1];
	assign root      = root_s[RT_W-1];
	assign side_out  = side_s[RT_W-1];

endmodule

[sv/lse_div.sv]
`timescale 1ns / 1ps

module lse_div import lse_pkg::*; #(
	parameter int NUM_W  = DNUM_W,
	parameter int DEN_W  = DDEN_W,
	parameter int Q_W    = DQ_W,
	parameter int LANES  = 1,
	parameter int SIDE_W = 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [LANES-1:0][NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]             den,
	input  logic [SIDE_W-1:0]            side_in,
	output logic                         out_valid,
	output logic [LANES-1:0][Q_W-1:0]    quo,
	output logic [SIDE_W-1:0]            side_out
);

	logic [Q_W-1:0]                          vld_s;
	logic [Q_W-1:0][LANES-1:0][DEN_W-1:0]    rem_s;
	logic [Q_W-1:0][LANES-1:0][Q_W-1:0]      low_s;
	logic [Q_W-1:0][LANES-1:0][Q_W-1:0]      quo_s;
	logic [Q_W-1:0][DEN_W-1:0]               den_s;
	logic [Q_W-1:0][SIDE_W-1:0]              side_s;

	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		logic                          p_vld;
		logic [LANES-1:0][DEN_W-1:0]   p_rem;
		logic [LANES-1:0][Q_W-1:0]     p_low;
		logic [LANES-1:0][Q_W-1:0]     p_quo;
		logic [DEN_W-1:0]              p_den;
		logic [SIDE_W-1:0]             p_side;
		logic [LANES-1:0][DEN_W:0]     t;
		logic [LANES-1:0]              ge;

		if (k == 0) begin : g_first
			assign p_vld  = in_valid;
			assign p_den  = den;
			assign p_side = side_in;
			for (genvar l = 0; l < LANES; l++) begin : g_lane
				assign p_rem[l] = DEN_W'(num[l] >> Q_W);
				assign p_low[l] = num[l][Q_W-1:0];
				assign p_quo[l] = '0;
			end
		end else begin : g_next
			assign p_vld  = vld_s[k-1];
			assign p_rem  = rem_s[k-1];
			assign p_low  = low_s[k-1];
			assign p_quo  = quo_s[k-1];
			assign p_den  = den_s[k-1];
			assign p_side = side_s[k-1];
		end

		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				t[l]  = {p_rem[l], p_low[l][Q_W-1]};
				ge[l] = t[l] >= {1'b0, p_den};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= p_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k]  <= p_den;
				side_s[k] <= p_side;
				for (int l = 0; l < LANES; l++) begin
					rem_s[k][l] <= ge[l] ? DEN_W'(t[l] - {1'b0, p_den}) : t[l][DEN_W-1:0];
					low_s[k][l] <= p_low[l] << 1;
					quo_s[k][l] <= {p_quo[l][Q_W-2:0], ge[l]};
				end
			end
		end
	end

	assign out_valid = vld_s[Q_W-1];
	assign quo       = quo_s[Q_W-1];
	assign side_out  = side_s[Q_W-1];

endmodule

[sv/light_sample_evaluator_unit.sv]
`timescale 1ns / 1ps

// Light sample evaluator: one configured light (point or directional) evaluated at a
// stream of hit points. Fully pipelined: one hit point accepted per cycle unless the
// result channel stalls, which freezes the whole pipeline; one result per hit point,
// through 4 front stages for difference, squares and sum, 33 square-root stages one
// root bit each, 32 intensity-division stages one quotient bit each, 15 three-lane
// direction-division stages and the output register. The user writes configuration
// through cfg only while no request is in flight (not enforced); cfg is always ready.
module light_sample_evaluator_unit import lse_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	lse_hit_if.sink    hit,
	lse_res_if.source  res,
	lse_cfg_if.sink    cfg
);

	logic                   type_q;
	logic [2:0][CRD_W-1:0]  vec_q;
	logic [PWR_W-1:0]       power_q;

	logic                   en;
	logic                   fr_vld;
	sq_side_t               fr_side;
	logic [SUM_W-1:0]       fr_sum;
	logic                   sq_vld;
	logic [ROOT_W-1:0]      sq_root;
	logic [$bits(sq_side_t)-1:0] sq_side_bits;
	sq_side_t               sq_o;
	id_side_t               id_in;
	logic                   id_vld;
	logic [0:0][IQ_W-1:0]   id_quo;
	logic [$bits(id_side_t)-1:0] id_side_bits;
	id_side_t               id_o;
	dd_side_t               dd_in;
	logic                   dd_vld;
	logic [2:0][DQ_W-1:0]   dd_quo;
	logic [$bits(dd_side_t)-1:0] dd_side_bits;
	dd_side_t               dd_o;
	logic [2:0][DIR_W-1:0]  dir;

	logic                   out_vld_q;
	logic [2:0][DIR_W-1:0]  dir_q;
	logic [DIST_W-1:0]      dist_q;
	logic                   inf_q;
	logic [PWR_W-1:0]       inten_q;
	logic                   zero_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_q  <= 1'b0;
			vec_q   <= '0;
			power_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_TYPE:  type_q   <= cfg.data[0];
				CFG_VEC_X: vec_q[0] <= cfg.data;
				CFG_VEC_Y: vec_q[1] <= cfg.data;
				CFG_VEC_Z: vec_q[2] <= cfg.data;
				CFG_POWER: power_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	assign en        = !out_vld_q || res.ready;
	assign hit.ready = en;

	lse_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (hit.valid),
		.hit       ({hit.hit_z, hit.hit_y, hit.hit_x}),
		.point     (type_q),
		.lvec      (vec_q),
		.power     (power_q),
		.out_valid (fr_vld),
		.side      (fr_side),
		.sum       (fr_sum)
	);

	lse_sqrt #(
		.RT_W   (ROOT_W),
		.SIDE_W ($bits(sq_side_t))
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fr_vld),
		.rad       (fr_sum),
		.side_in   (fr_side),
		.out_valid (sq_vld),
		.root      (sq_root),
		.side_out  (sq_side_bits)
	);

	assign sq_o = sq_side_t'(sq_side_bits);

	always_comb begin
		id_in.point      = sq_o.point;
		id_in.neg        = sq_o.neg;
		id_in.s_zero     = sq_o.s_zero;
		id_in.force_max  = sq_o.force_max;
		id_in.force_zero = sq_o.force_zero;
		id_in.power      = sq_o.power;
		id_in.len        = sq_root;
		id_in.dden       = sq_o.s_zero ? DDEN_W'(1) : sq_root;
		for (int i = 0; i < 3; i++) begin
			if (sq_o.s_zero)
				id_in.dnum[i] = '0;
			else
				id_in.dnum[i] = DNUM_W'({sq_o.mag[i], {FRAC_DIR{1'b0}}})
					+ DNUM_W'(sq_root >> 1);
		end
	end

	lse_div #(
		.NUM_W  (INUM_W),
		.DEN_W  (IDEN_W),
		.Q_W    (IQ_W),
		.LANES  (1),
		.SIDE_W ($bits(id_side_t))
	) u_idiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_vld),
		.num       (sq_o.inum),
		.den       (sq_o.iden),
		.side_in   (id_in),
		.out_valid (id_vld),
		.quo       (id_quo),
		.side_out  (id_side_bits)
	);

	assign id_o = id_side_t'(id_side_bits);

	always_comb begin
		dd_in.point  = id_o.point;
		dd_in.neg    = id_o.neg;
		dd_in.s_zero = id_o.s_zero;
		dd_in.len    = id_o.len;
		if (!id_o.point)
			dd_in.inten = id_o.power;
		else if (id_o.force_max)
			dd_in.inten = '1;
		else if (id_o.force_zero)
			dd_in.inten = '0;
		else
			dd_in.inten = id_quo[0];
	end

	lse_div #(
		.NUM_W  (DNUM_W),
		.DEN_W  (DDEN_W),
		.Q_W    (DQ_W),
		.LANES  (3),
		.SIDE_W ($bits(dd_side_t))
	) u_ddiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (id_vld),
		.num       (id_o.dnum),
		.den       (id_o.dden),
		.side_in   (dd_in),
		.out_valid (dd_vld),
		.quo       (dd_quo),
		.side_out  (dd_side_bits)
	);

	assign dd_o = dd_side_t'(dd_side_bits);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (dd_o.s_zero)
				dir[i] = '0;
			else if (dd_o.neg[i])
				dir[i] = '0 - {1'b0, dd_quo[i]};
			else
				dir[i] = {1'b0, dd_quo[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= dd_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dir_q   <= dir;
			dist_q  <= dd_o.point ? dd_o.len : '0;
			inf_q   <= !dd_o.point;
			inten_q <= dd_o.inten;
			zero_q  <= dd_o.s_zero;
		end
	end

	assign res.valid              = out_vld_q;
	assign res.dir_x              = dir_q[0];
	assign res.dir_y              = dir_q[1];
	assign res.dir_z              = dir_q[2];
	assign res.light_distance     = dist_q;
	assign res.distance_infinite  = inf_q;
	assign res.arriving_intensity = inten_q;
	assign res.zero_vector        = zero_q;

`ifndef SYNTHESIS
	a_zero_dir: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.zero_vector |-> res.dir_x == '0 && res.dir_y == '0 && res.dir_z == '0)
		else $error("zero vector with nonzero direction");

	a_inf_dist: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.distance_infinite |-> res.light_distance == '0)
		else $error("directional light with nonzero distance");

	a_zero_sat: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.distance_infinite && res.zero_vector |->
		res.arriving_intensity == '1 && res.light_distance == '0)
		else $error("point light at zero range not saturated");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(dd_side_bits) && $stable(dd_vld))
		else $error("pipeline moved during stall");
`endif

endmodule
